// File: src/hf2ieee_pkg.sv
package hf2ieee_pkg;

  localparam int WordW = 32;
  localparam int ExpW  = 7;
  localparam int FracW = 24;
  localparam int MantW = 23;
  localparam int ShW   = 5;
  localparam int E2W   = 10;

  localparam logic [E2W-1:0]        HexBias     = 10'd64;
  localparam logic signed [E2W-1:0] ExpMax      = 10'sd127;
  localparam logic signed [E2W-1:0] ExpMinDen   = -10'sd149;
  localparam logic signed [E2W-1:0] ExpMinNorm  = -10'sd126;
  localparam logic signed [E2W-1:0] Ieee754Bias = 10'sd127;
  localparam logic [7:0]            ExpAllOnes  = 8'hff;

  // leading-zero count of a nonzero 24-bit fraction, capped at 23
  function automatic logic [ShW-1:0] lzc24(input logic [FracW-1:0] f);
    logic [ShW-1:0] cnt;
    cnt = ShW'(FracW - 1);
    for (int i = 0; i < FracW; i++) begin
      if (f[i]) begin
        cnt = ShW'(FracW - 1 - i);
      end
    end
    return cnt;
  endfunction

endpackage

// File: src/hex_float_to_ieee_single_core.sv
// hex float (base-16, excess-64 exponent) to ieee 754 single converter
//
// input channel: drive in_hex_float and raise start; the item is taken at
//   the rising edge where start is high and busy is low. busy is always
//   low here, so a new item may be offered on every cycle.
// result channel: out_valid is high for exactly one cycle with the
//   converted word on out_ieee_single. the receiver cannot hold results off.
// pipeline: three register stages lie between the accepting edge and
//   the result (leading-zero count, normalize and exponent, classify
//   and pack).
// throughput: one item per cycle; every stage is a plain register stage
//   with a valid bit, so items flow without gaps.
// reset: rst_n low at a rising edge clears all valid bits; items in
//   flight are dropped and no result is shown until new items arrive.
// truncation only, never rounding; a zero fraction gives +0, overflow a
//   signed infinity and deep underflow a signed zero.
module hex_float_to_ieee_single_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_hex_float,
  output logic        out_valid,
  output logic [31:0] out_ieee_single
);

  // stage 1 registers: split fields and leading-zero count
  logic                           s1_valid_r, s1_valid_nxt;
  logic                           s1_sign_r;
  logic                           s1_zero_r;
  logic [hf2ieee_pkg::ExpW-1:0]   s1_exp_r;
  logic [hf2ieee_pkg::FracW-1:0]  s1_frac_r;
  logic [hf2ieee_pkg::ShW-1:0]    s1_lzc_r;

  // stage 2 registers: normalized fraction and base-2 exponent
  logic                           s2_valid_r, s2_valid_nxt;
  logic                           s2_sign_r;
  logic                           s2_zero_r;
  logic [hf2ieee_pkg::FracW-1:0]  s2_frac_r, s2_frac_nxt;
  logic signed [hf2ieee_pkg::E2W-1:0] s2_e2_r, s2_e2_nxt;

  // output registers
  logic                           out_valid_r;
  logic [31:0]                    out_ieee_single_r, out_ieee_single_nxt;

  logic                           accept;
  logic signed [hf2ieee_pkg::E2W-1:0] den_sh_full;
  logic [hf2ieee_pkg::ShW-1:0]    den_sh;
  logic [hf2ieee_pkg::FracW-1:0]  den_frac;
  logic [7:0]                     norm_exp;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: capture the word and count leading zeros
  assign s1_valid_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sign_r <= in_hex_float[31];
      s1_exp_r  <= in_hex_float[30:24];
      s1_frac_r <= in_hex_float[23:0];
      s1_zero_r <= (in_hex_float[23:0] == '0);
      s1_lzc_r  <= hf2ieee_pkg::lzc24(in_hex_float[23:0]);
    end
  end

  // stage 2: normalize and form the base-2 exponent
  assign s2_valid_nxt = s1_valid_r;

  always_comb begin
    s2_frac_nxt = s1_frac_r << s1_lzc_r;
    s2_e2_nxt   = signed'((({3'b000, s1_exp_r} - hf2ieee_pkg::HexBias) << 2)
                          - {5'b00000, s1_lzc_r} - 10'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_sign_r <= s1_sign_r;
      s2_zero_r <= s1_zero_r;
      s2_frac_r <= s2_frac_nxt;
      s2_e2_r   <= s2_e2_nxt;
    end
  end

  // stage 3: classify, denormal shift and pack
  always_comb begin
    den_sh_full = hf2ieee_pkg::ExpMinNorm - s2_e2_r;
    den_sh      = den_sh_full[hf2ieee_pkg::ShW-1:0];
    den_frac    = s2_frac_r >> den_sh;
    norm_exp    = 8'(s2_e2_r + hf2ieee_pkg::Ieee754Bias);

    if (s2_zero_r) begin
      out_ieee_single_nxt = '0;
    end else if (s2_e2_r > hf2ieee_pkg::ExpMax) begin
      out_ieee_single_nxt = {s2_sign_r, hf2ieee_pkg::ExpAllOnes, 23'd0};
    end else if (s2_e2_r < hf2ieee_pkg::ExpMinDen) begin
      out_ieee_single_nxt = {s2_sign_r, 31'd0};
    end else if (s2_e2_r >= hf2ieee_pkg::ExpMinNorm) begin
      out_ieee_single_nxt = {s2_sign_r, norm_exp,
                             s2_frac_r[hf2ieee_pkg::MantW-1:0]};
    end else begin
      out_ieee_single_nxt = {s2_sign_r, 8'd0,
                             den_frac[hf2ieee_pkg::MantW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      out_ieee_single_r <= out_ieee_single_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ieee_single = out_ieee_single_r;

`ifndef SYNTH
  // every result traces back to an item held in stage 1 and then in stage 2
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s1_valid_r, 2))
    else $error("result without an item in flight");

  // an all-ones exponent field only ever carries a zero mantissa
  a_inf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ieee_single_r[30:23] == hf2ieee_pkg::ExpAllOnes)
    |-> (out_ieee_single_r[22:0] == 23'd0))
    else $error("nan pattern produced");

  // a nonzero fraction is normalized with its top bit set
  a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_zero_r) |-> s2_frac_r[hf2ieee_pkg::FracW-1])
    else $error("normalized fraction lacks its top bit");
`endif

endmodule

// File: tb/hex_float_to_ieee_single_scoreboard.sv
`timescale 1ns / 1ps

module hex_float_to_ieee_single_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [hf2ieee_pkg::WordW-1:0] in_hex_float,
  input  logic                          out_valid,
  input  logic [hf2ieee_pkg::WordW-1:0] out_ieee_single,
  output int                            fail_count,
  output int                            pending,
  output int                            n_normal,
  output int                            n_denormal,
  output int                            n_infinity,
  output int                            n_zero
);

  localparam int HexExpBias   = 64;
  localparam int Bin32ExpBias = 127;
  localparam int MaxBinExp    = 127;
  localparam int MinDenormExp = -149;
  localparam int MinNormExp   = -126;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_DENORMAL,
    CLS_NORMAL,
    CLS_INFINITY
  } single_class_t;

  logic [hf2ieee_pkg::WordW-1:0] expected_singles[$];

  // base-16 word to binary32, fraction bits beyond the field are dropped
  function automatic logic [hf2ieee_pkg::WordW-1:0] single_of_hex(
      input logic [hf2ieee_pkg::WordW-1:0] w);
    logic                          sgn;
    logic [hf2ieee_pkg::FracW-1:0] f;
    int                            lead;
    int                            e2;
    sgn  = w[hf2ieee_pkg::WordW-1];
    f    = w[hf2ieee_pkg::FracW-1:0];
    lead = 0;
    if (f == '0) begin
      return '0;
    end
    while (!f[hf2ieee_pkg::FracW-1]) begin
      f    = f << 1;
      lead = lead + 1;
    end
    e2 = (int'(w[hf2ieee_pkg::WordW-2:hf2ieee_pkg::FracW]) - HexExpBias) * 4
         - lead - 1;
    if (e2 > MaxBinExp) begin
      return {sgn, 8'hff, 23'd0};
    end
    if (e2 < MinDenormExp) begin
      return {sgn, 31'd0};
    end
    if (e2 >= MinNormExp) begin
      return {sgn, 8'(e2 + Bin32ExpBias), f[hf2ieee_pkg::MantW-1:0]};
    end
    // denormal: shift the normalized significand right, bits fall off
    f = f >> (MinNormExp - e2);
    return {sgn, 8'd0, f[hf2ieee_pkg::MantW-1:0]};
  endfunction

  function automatic single_class_t class_of(input logic [hf2ieee_pkg::WordW-1:0] s);
    if (s[30:23] == 8'hff) begin
      return CLS_INFINITY;
    end
    if (s[30:23] != 8'd0) begin
      return CLS_NORMAL;
    end
    if (s[hf2ieee_pkg::MantW-1:0] != '0) begin
      return CLS_DENORMAL;
    end
    return CLS_ZERO;
  endfunction

  assign pending = expected_singles.size();

  // compare results first (a result never comes in the cycle its item is taken), then log new items
  always @(posedge clk) begin
    logic [hf2ieee_pkg::WordW-1:0] exp_word;
    if (!rst_n) begin
      expected_singles.delete();
      fail_count <= 0;
      n_normal   <= 0;
      n_denormal <= 0;
      n_infinity <= 0;
      n_zero     <= 0;
    end else begin
      if (out_valid) begin
        if (expected_singles.size() == 0) begin
          $error("out_ieee_single: result %h with no item outstanding", out_ieee_single);
          fail_count <= fail_count + 1;
        end else begin
          exp_word = expected_singles.pop_front();
          if (out_ieee_single !== exp_word) begin
            $error("out_ieee_single: expected %h, actual %h", exp_word, out_ieee_single);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        exp_word = single_of_hex(in_hex_float);
        expected_singles.push_back(exp_word);
        case (class_of(exp_word))
          CLS_ZERO:     n_zero     <= n_zero + 1;
          CLS_DENORMAL: n_denormal <= n_denormal + 1;
          CLS_NORMAL:   n_normal   <= n_normal + 1;
          default:      n_infinity <= n_infinity + 1;
        endcase
      end
    end
  end

endmodule

// File: tb/hex_float_to_ieee_single_core_test.sv
`timescale 1ns / 1ps

module hex_float_to_ieee_single_core_test;

  localparam int ItemsPerPhase = 325;
  localparam int NumPhases     = 4;
  localparam int DrainCycles   = 8;
  localparam int CycleLimit    = 200000;
  localparam int NumCorners    = 24;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [hf2ieee_pkg::WordW-1:0] in_hex_float;
  logic                          out_valid;
  logic [hf2ieee_pkg::WordW-1:0] out_ieee_single;

  int fail_count;
  int pending;
  int n_normal;
  int n_denormal;
  int n_infinity;
  int n_zero;
  int cycle_count;
  int items_sent;

  // sender idle percentage per phase
  int idle_pct[NumPhases] = '{0, 86, 0, 12};

  // corner words: signs, exponent extremes, range boundaries
  logic [hf2ieee_pkg::WordW-1:0] corner_words[NumCorners] = '{
    32'h0000_0000, 32'h8000_0000, 32'hff00_0000, 32'h7f00_0000,
    32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0001,
    32'h0080_0000, 32'h7f00_0001, 32'h4110_0000, 32'hc110_0000,
    32'h6080_0000, 32'he040_0000, 32'h6110_0000, 32'h6108_0000,
    32'h2110_0000, 32'ha120_0000, 32'h21ff_ffff, 32'h1b80_0000,
    32'h9bff_ffff, 32'h1b40_0000, 32'h2000_0001, 32'h4000_0001
  };

  hex_float_to_ieee_single_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_hex_float    (in_hex_float),
    .out_valid       (out_valid),
    .out_ieee_single (out_ieee_single)
  );

  hex_float_to_ieee_single_scoreboard i_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_hex_float    (in_hex_float),
    .out_valid       (out_valid),
    .out_ieee_single (out_ieee_single),
    .fail_count      (fail_count),
    .pending         (pending),
    .n_normal        (n_normal),
    .n_denormal      (n_denormal),
    .n_infinity      (n_infinity),
    .n_zero          (n_zero)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[hex_float_to_ieee_single_core] ERROR");
      $finish;
    end
  end

  // mostly words near the representable range with varied leading zeros
  function automatic logic [hf2ieee_pkg::WordW-1:0] random_word();
    logic [hf2ieee_pkg::FracW-1:0] f;
    logic [hf2ieee_pkg::ExpW-1:0]  e;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    e = hf2ieee_pkg::ExpW'($urandom_range(24, 100));
    f = hf2ieee_pkg::FracW'($urandom) & (24'hff_ffff >> $urandom_range(0, 23));
    if ($urandom_range(0, 19) == 0) begin
      f = '0;
    end
    return {1'($urandom), e, f};
  endfunction

  // offer one item, holding start until it is taken
  task automatic send_word(input logic [hf2ieee_pkg::WordW-1:0] w, input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_hex_float <= w;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    cycle_count  = 0;
    items_sent   = 0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_hex_float <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, back to back
    foreach (corner_words[i]) begin
      send_word(corner_words[i], 0);
    end
    wait_drained();

    // random phases, drained between them
    for (int p = 0; p < NumPhases; p++) begin
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_word(random_word(), idle_pct[p]);
      end
      wait_drained();
    end
    repeat (DrainCycles) @(posedge clk);

    $display("converted %0d words: %0d normal, %0d denormal, %0d infinity, %0d zero",
             items_sent, n_normal, n_denormal, n_infinity, n_zero);
    $display("sender gaps of 0, 86 and 12 percent, queue drained between phases");
    if (fail_count == 0 && pending == 0) begin
      $display("[hex_float_to_ieee_single_core] OK");
    end else begin
      $display("[hex_float_to_ieee_single_core] ERROR");
    end
    $finish;
  end

endmodule
